// ===== rtl/dtsg_pkg.sv =====
// Shared types, constants and helpers of the dual tone square wave generator.
`timescale 1ns / 1ps

package dtsg_pkg;

  // System clock and derived tone timing constants
  localparam int unsigned ClockHz    = 120000000;
  localparam logic [31:0] TickDiv    = 32'(ClockHz / 128);
  localparam logic [11:0] HalfLevel  = 12'd2047;
  localparam logic [15:0] CmpMax     = 16'hFFFF;
  localparam int unsigned DivSteps   = 32;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  // Half periods = floor(x / 500) = ((x >> 2) * ceil(2^37 / 125)) >> 37,
  // exact for every x below 2^32
  localparam logic [30:0] ToggleRecip = 31'd1099511628;
  localparam int unsigned ToggleShift = 37;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } dtsg_op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK0,
    ST_TICK1,
    ST_DIV_CMP,
    ST_DONE
  } dtsg_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_in;
    logic tick_en;
    logic tick_ch;
    logic div_start;
    logic load_cmp;
    logic load_tog;
    logic stop_en;
    logic load_out;
  } dtsg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       div_done;
  } dtsg_stat_t;

  // DAC level for a pair of wave states
  function automatic logic [11:0] level_of(input logic [1:0] wave);
    logic [11:0] lvl;
    lvl = (wave[0] ? HalfLevel : 12'd0) + (wave[1] ? HalfLevel : 12'd0);
    return lvl;
  endfunction

endpackage

// ===== rtl/dtsg_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dtsg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import dtsg_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic [16:0]        shifted;
  logic [16:0]        diff;
  logic               ge;

  // One restoring step
  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[15:0] : shifted[15:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DivCntW'(DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/dtsg_datapath.sv =====
// Tone channel state, tick processing, start setup and result register.
`timescale 1ns / 1ps

module dtsg_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dtsg_pkg::dtsg_cmd_t  cmd,
  output dtsg_pkg::dtsg_stat_t stat,
  input  logic [1:0]         in_opcode,
  input  logic               in_channel,
  input  logic [15:0]        in_freq_hz,
  input  logic [15:0]        in_duration_ms,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_audio_enable,
  output logic [11:0]        out_dac_level,
  output logic               out_first_playing,
  output logic               out_second_playing
);
  import dtsg_pkg::*;

  // Latched input beat
  logic [1:0]  op_r;
  logic        ch_r;
  logic [15:0] freq_r;
  logic [15:0] dur_r;

  // Channel state
  logic        audio_r;
  logic [1:0]  running_r, running_nxt;
  logic [1:0]  wave_r, wave_nxt;
  logic [1:0]  endless_r, endless_nxt;
  logic [15:0] cnt_r [2];
  logic [15:0] cnt_nxt [2];
  logic [15:0] cmp_r [2];
  logic [15:0] cmp_nxt [2];
  logic [31:0] tog_r [2];
  logic [31:0] tog_nxt [2];
  logic [11:0] level_r, level_nxt;

  // Result register
  logic [11:0] out_level_r;
  logic [1:0]  out_run_r;

  // Divider hookup and half-period count
  logic [31:0] prod;
  logic [31:0] prod_r;
  logic [60:0] tog_mul;
  logic [31:0] tog_calc;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [31:0] div_q;
  logic [15:0] cmp_calc;

  assign prod         = 32'(freq_r) * 32'(dur_r);
  assign div_dividend = TickDiv;
  assign div_divisor  = freq_r;

  // freq * dur / 500 by reciprocal multiply on the registered product
  assign tog_mul  = 61'(prod_r[31:2]) * 61'(ToggleRecip);
  assign tog_calc = 32'(tog_mul[60:ToggleShift]);

  dtsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Compare value: quotient minus one, saturated
  always_comb begin
    if (freq_r == 16'd0) begin
      cmp_calc = CmpMax;
    end else if (div_q == 32'd0) begin
      cmp_calc = 16'd0;
    end else if (div_q > 32'h0001_0000) begin
      cmp_calc = CmpMax;
    end else begin
      cmp_calc = 16'(div_q - 32'd1);
    end
  end

  // Channel state update
  always_comb begin
    running_nxt = running_r;
    wave_nxt    = wave_r;
    endless_nxt = endless_r;
    cnt_nxt     = cnt_r;
    cmp_nxt     = cmp_r;
    tog_nxt     = tog_r;
    level_nxt   = level_r;

    if (cmd.tick_en && running_r[cmd.tick_ch]) begin
      if (cnt_r[cmd.tick_ch] == cmp_r[cmd.tick_ch]) begin
        cnt_nxt[cmd.tick_ch] = 16'd0;
        if (endless_r[cmd.tick_ch] || (tog_r[cmd.tick_ch] != 32'd0)) begin
          if (!endless_r[cmd.tick_ch]) begin
            tog_nxt[cmd.tick_ch] = tog_r[cmd.tick_ch] - 32'd1;
          end
          if (audio_r) begin
            wave_nxt[cmd.tick_ch] = ~wave_r[cmd.tick_ch];
            level_nxt             = level_of(wave_nxt);
          end
        end else begin
          running_nxt[cmd.tick_ch] = 1'b0;
          wave_nxt[cmd.tick_ch]    = 1'b0;
        end
      end else begin
        cnt_nxt[cmd.tick_ch] = cnt_r[cmd.tick_ch] + 16'd1;
      end
    end

    if (cmd.stop_en) begin
      running_nxt[ch_r] = 1'b0;
      wave_nxt[ch_r]    = 1'b0;
    end

    if (cmd.load_cmp) begin
      cmp_nxt[ch_r] = cmp_calc;
    end

    if (cmd.load_tog) begin
      endless_nxt[ch_r] = (dur_r == 16'd0);
      tog_nxt[ch_r]     = (dur_r == 16'd0) ? 32'd0 : tog_calc;
      cnt_nxt[ch_r]     = 16'd0;
      running_nxt[ch_r] = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_r   <= 1'b1;
      running_r <= '0;
      wave_r    <= '0;
      endless_r <= '0;
      cnt_r     <= '{default: '0};
      cmp_r     <= '{default: '0};
      tog_r     <= '{default: '0};
      level_r   <= '0;
    end else begin
      if (cfg_valid) begin
        audio_r <= cfg_audio_enable;
      end
      running_r <= running_nxt;
      wave_r    <= wave_nxt;
      endless_r <= endless_nxt;
      cnt_r     <= cnt_nxt;
      cmp_r     <= cmp_nxt;
      tog_r     <= tog_nxt;
      level_r   <= level_nxt;
    end
  end

  // Input latch, product register and result register
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_opcode;
      ch_r   <= in_channel;
      freq_r <= in_freq_hz;
      dur_r  <= in_duration_ms;
    end
    prod_r <= prod;
    if (cmd.load_out) begin
      out_level_r <= level_r;
      out_run_r   <= running_r;
    end
  end

  assign cfg_ready          = 1'b1;
  assign stat.opcode        = op_r;
  assign stat.div_done      = div_done;
  assign out_dac_level      = out_level_r;
  assign out_first_playing  = out_run_r[0];
  assign out_second_playing = out_run_r[1];

`ifndef ASSERT_OFF
  // Level only ever takes the sum of zero, one or two half levels
  a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r == 12'd0) || (level_r == HalfLevel) || (level_r == 12'(2 * HalfLevel)))
    else $error("dac level outside legal set");

  // A stopped channel never holds its wave high
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((~running_r & wave_r) == 2'b00))
    else $error("wave high on stopped channel");

  // A tick leaves the counter of a stopped first channel alone
  a_tick_hold0: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick_en && !cmd.tick_ch && !running_r[0]) |=> $stable(cnt_r[0]))
    else $error("stopped counter moved on tick");
`endif

endmodule

// ===== rtl/dtsg_ctrl.sv =====
// Sequencing state machine: decode, tick steps, divider wait, result handoff.
`timescale 1ns / 1ps

module dtsg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dtsg_pkg::dtsg_stat_t stat,
  output dtsg_pkg::dtsg_cmd_t  cmd
);
  import dtsg_pkg::*;

  dtsg_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.opcode)
          OP_TICK: begin
            state_nxt = ST_TICK0;
          end
          OP_START: begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV_CMP;
          end
          OP_STOP: begin
            cmd.stop_en = 1'b1;
            state_nxt   = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_TICK0: begin
        cmd.tick_en = 1'b1;
        cmd.tick_ch = 1'b0;
        state_nxt   = ST_TICK1;
      end
      ST_TICK1: begin
        cmd.tick_en = 1'b1;
        cmd.tick_ch = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DIV_CMP: begin
        if (stat.div_done) begin
          cmd.load_cmp = 1'b1;
          cmd.load_tog = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // A result is loaded only into a free or draining output slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result beat overwritten");

  // Every accepted beat leads to the decode step
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted beat not decoded");

  // Divider is only started from decode
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (state_r == ST_DECODE))
    else $error("stray divider start");
`endif

endmodule

// ===== rtl/dual_tone_square_wave_generator_unit.sv =====
// Top level of the dual tone square wave generator.
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: opcode 0 is a
//   prescaled timer tick, 1 starts a tone on in_channel with in_freq_hz and
//   in_duration_ms (0 plays until stopped), 2 stops the tone on in_channel.
//   Every beat yields one result beat on the output channel
//   (out_valid/out_ready): DAC level and the playing flag of each channel.
//   Config channel (cfg_valid/cfg_ready) writes audio_enable; always ready.
// Sequencing:
//   One beat is processed at a time. A tick runs from accept to result
//   through decode, one step per channel and result load; stop and unused
//   opcodes run through decode and result load. A start waits on the
//   divider for the compare value; the half-period count is a multiply by
//   a constant reciprocal. The next beat is taken once the result is loaded.
// Reset: rst_n is synchronous active low; both channels stop, level is 0,
//   audio_enable is 1.
// Stall: a held result waits in the output register; one more beat may be
//   accepted and worked on, and its result waits until the slot frees.
`timescale 1ns / 1ps

module dual_tone_square_wave_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic        in_channel,
  input  logic [15:0] in_freq_hz,
  input  logic [15:0] in_duration_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_dac_level,
  output logic        out_first_playing,
  output logic        out_second_playing,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_audio_enable
);
  import dtsg_pkg::*;

  dtsg_cmd_t  cmd;
  dtsg_stat_t stat;

  // Sequencer
  dtsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Channel datapath
  dtsg_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_channel         (in_channel),
    .in_freq_hz         (in_freq_hz),
    .in_duration_ms     (in_duration_ms),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_audio_enable   (cfg_audio_enable),
    .out_dac_level      (out_dac_level),
    .out_first_playing  (out_first_playing),
    .out_second_playing (out_second_playing)
  );

endmodule

// ===== sim/dtsg_status_checker.sv =====
// Status checker for the dual tone generator: tracks tone state and compares each beat.
`timescale 1ns / 1ps

module dtsg_status_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic        in_channel,
  input  logic [15:0] in_freq_hz,
  input  logic [15:0] in_duration_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [11:0] out_dac_level,
  input  logic        out_first_playing,
  input  logic        out_second_playing,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_audio_enable,
  output int unsigned mismatch_count,
  output int unsigned status_pending
);
  import dtsg_pkg::*;

  localparam longint unsigned MsPerSec = 1000;
  localparam longint unsigned PrescaleDiv = 128;

  typedef struct packed {
    logic [11:0] level;
    logic        first;
    logic        second;
  } tone_status_t;

  // Status beats still owed by the block, oldest first
  tone_status_t expected_status[$];

  // Tracked tone state
  logic        audio_on;
  logic [1:0]  playing;
  logic [1:0]  endless;
  logic [1:0]  wave_hi;
  logic [15:0] tick_cnt [2];
  logic [15:0] cmp_val [2];
  logic [31:0] halves_left [2];
  logic [11:0] dac_level;

  // Compare value for a frequency, clamped to the 16-bit counter range
  function automatic logic [15:0] compare_for(input logic [15:0] freq);
    longint unsigned q;
    if (freq == 16'd0) return CmpMax;
    q = longint'(ClockHz) / (PrescaleDiv * longint'(freq));
    if (q == 0) return 16'd0;
    if (q - 1 > longint'(CmpMax)) return CmpMax;
    return 16'(q - 1);
  endfunction

  // Counter match on channel c: count down and flip, or stop when spent
  task automatic toggle_event(input int c);
    if (endless[c] || halves_left[c] != 32'd0) begin
      if (!endless[c]) halves_left[c] = halves_left[c] - 32'd1;
      if (audio_on) begin
        wave_hi[c] = ~wave_hi[c];
        dac_level = (wave_hi[0] ? HalfLevel : 12'd0) + (wave_hi[1] ? HalfLevel : 12'd0);
      end
    end else begin
      playing[c] = 1'b0;
      wave_hi[c] = 1'b0;
    end
  endtask

  // Advance the tracked state by one command beat and queue its status
  task automatic apply_command(input logic [1:0] op, input logic ch,
                               input logic [15:0] freq, input logic [15:0] dur);
    tone_status_t st;
    case (op)
      OP_TICK: begin
        for (int c = 0; c < 2; c++) begin
          if (playing[c]) begin
            if (tick_cnt[c] == cmp_val[c]) begin
              tick_cnt[c] = 16'd0;
              toggle_event(c);
            end else begin
              tick_cnt[c] = tick_cnt[c] + 16'd1;
            end
          end
        end
      end
      OP_START: begin
        cmp_val[ch] = compare_for(freq);
        endless[ch] = (dur == 16'd0);
        halves_left[ch] = (dur == 16'd0) ? 32'd0 :
                          32'((longint'(freq) * longint'(dur) * 2) / MsPerSec);
        tick_cnt[ch] = 16'd0;
        playing[ch] = 1'b1;
      end
      OP_STOP: begin
        playing[ch] = 1'b0;
        wave_hi[ch] = 1'b0;
      end
      default: ;
    endcase
    st.level = dac_level;
    st.first = playing[0];
    st.second = playing[1];
    expected_status.push_back(st);
  endtask

  // Compare one status beat against the oldest expectation
  task automatic check_status(input logic [11:0] lvl, input logic first, input logic second);
    tone_status_t want;
    if (expected_status.size() == 0) begin
      $display("%0t: status beat with none expected: level %0d first %0b second %0b",
               $time, lvl, first, second);
      mismatch_count++;
      return;
    end
    want = expected_status.pop_front();
    if (lvl !== want.level) begin
      $display("%0t: dac_level expected %0d actual %0d", $time, want.level, lvl);
      mismatch_count++;
    end
    if (first !== want.first) begin
      $display("%0t: first_playing expected %0b actual %0b", $time, want.first, first);
      mismatch_count++;
    end
    if (second !== want.second) begin
      $display("%0t: second_playing expected %0b actual %0b", $time, want.second, second);
      mismatch_count++;
    end
  endtask

  // Watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      audio_on = 1'b1;
      playing = 2'b00;
      endless = 2'b00;
      wave_hi = 2'b00;
      dac_level = 12'd0;
      for (int c = 0; c < 2; c++) begin
        tick_cnt[c] = 16'd0;
        cmp_val[c] = 16'd0;
        halves_left[c] = 32'd0;
      end
      expected_status.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready)
        check_status(out_dac_level, out_first_playing, out_second_playing);
      if (cfg_valid && cfg_ready) audio_on = cfg_audio_enable;
      if (in_valid && in_ready)
        apply_command(in_opcode, in_channel, in_freq_hz, in_duration_ms);
    end
    status_pending <= expected_status.size();
  end

endmodule

// ===== sim/tb_dual_tone_square_wave_generator_unit.sv =====
// Testbench top for the dual tone generator: drives commands and audio enable, gives the verdict.
`timescale 1ns / 1ps

module tb_dual_tone_square_wave_generator_unit;
  import dtsg_pkg::*;

  localparam logic [1:0] OpSpare = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_TICK;
  logic        in_channel = 1'b0;
  logic [15:0] in_freq_hz = 16'd0;
  logic [15:0] in_duration_ms = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_dac_level;
  logic        out_first_playing;
  logic        out_second_playing;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_audio_enable = 1'b1;

  int unsigned mismatch_count;
  int unsigned status_pending;
  int unsigned cmds_sent = 0;
  int unsigned status_seen = 0;
  int          burst_left = 1;

  // Receiver stall pattern state
  int unsigned cycle_cnt = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_mode = 0;

  always #5 clk = ~clk;

  dual_tone_square_wave_generator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_channel        (in_channel),
    .in_freq_hz        (in_freq_hz),
    .in_duration_ms    (in_duration_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dac_level     (out_dac_level),
    .out_first_playing (out_first_playing),
    .out_second_playing(out_second_playing),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_audio_enable  (cfg_audio_enable)
  );

  dtsg_status_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_channel        (in_channel),
    .in_freq_hz        (in_freq_hz),
    .in_duration_ms    (in_duration_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dac_level     (out_dac_level),
    .out_first_playing (out_first_playing),
    .out_second_playing(out_second_playing),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_audio_enable  (cfg_audio_enable),
    .mismatch_count    (mismatch_count),
    .status_pending    (status_pending)
  );

  // Count status beats taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) status_seen <= status_seen + 1;
  end

  // Receiver: switch between stall patterns every so often
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_hold <= $urandom_range(20, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cycle_cnt[2:0] == 3'd0);
      default: out_ready <= cycle_cnt[1];
    endcase
  end

  // Send one command beat; sender works in bursts with idle gaps
  task automatic send_cmd(input logic [1:0] op, input logic ch,
                          input logic [15:0] freq, input logic [15:0] dur);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_channel <= ch;
    in_freq_hz <= freq;
    in_duration_ms <= dur;
    do @(posedge clk); while (!in_ready);
    cmds_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  // Random command, mostly ticks, starts tuned so tones toggle often
  task automatic random_cmd();
    int          pick;
    logic [1:0]  op;
    logic [15:0] freq;
    logic [15:0] dur;
    pick = $urandom_range(0, 99);
    freq = 16'($urandom);
    dur = 16'($urandom);
    op = OP_TICK;
    if (pick >= 96) begin
      op = OpSpare;
    end else if (pick >= 90) begin
      op = OP_STOP;
    end else if (pick >= 78) begin
      op = OP_START;
      if ($urandom_range(0, 9) < 7) freq = 16'($urandom_range(20000, 65535));
      pick = $urandom_range(0, 9);
      if (pick < 3) dur = 16'd0;
      else if (pick < 7) dur = 16'($urandom_range(1, 3));
    end
    send_cmd(op, 1'($urandom_range(0, 1)), freq, dur);
  endtask

  // Wait for every owed status beat
  task automatic drain();
    in_valid <= 1'b0;
    while (status_seen != cmds_sent) @(posedge clk);
  endtask

  task automatic write_audio(input logic en);
    cfg_valid <= 1'b1;
    cfg_audio_enable <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_audio(1'b1);

    // Idle commands, then extremes of frequency and duration
    send_cmd(OP_TICK, 1'b1, 16'hFFFF, 16'hFFFF);
    send_cmd(OP_STOP, 1'b0, 16'd0, 16'd0);
    send_cmd(OpSpare, 1'b1, 16'hA5A5, 16'h5A5A);
    send_cmd(OP_START, 1'b0, 16'hFFFF, 16'd0);
    send_cmd(OP_START, 1'b1, 16'd0, 16'hFFFF);
    send_cmd(OP_START, 1'b1, 16'd1, 16'hFFFF);
    send_cmd(OP_START, 1'b1, 16'hFFFF, 16'hFFFF);
    repeat (16) send_cmd(OP_TICK, 1'b0, 16'd0, 16'd0);
    send_cmd(OP_STOP, 1'b1, 16'd0, 16'd0);
    send_cmd(OP_STOP, 1'b0, 16'd0, 16'd0);

    repeat (250) random_cmd();
    drain();
    write_audio(1'b0);
    repeat (200) random_cmd();
    drain();
    write_audio(1'b1);
    repeat (250) random_cmd();
    drain();

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && status_pending == 0 && status_seen == cmds_sent)
      $display("tb_dual_tone_square_wave_generator_unit OK");
    else
      $display("tb_dual_tone_square_wave_generator_unit NOT OK");
    $finish;
  end

  // Hang guard
  initial begin
    #10000000;
    $display("tb_dual_tone_square_wave_generator_unit NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dtsg_pkg.sv
rtl/dtsg_div.sv
rtl/dtsg_datapath.sv
rtl/dtsg_ctrl.sv
rtl/dual_tone_square_wave_generator_unit.sv
sim/dtsg_status_checker.sv
sim/tb_dual_tone_square_wave_generator_unit.sv
